>>> rtl/core/mm3_pkg.sv
// Shared constants and types for the MurmurHash3 x64 128-bit streaming hash.
// Used by every module of the block; depends on nothing.
package mm3_pkg;

  localparam int unsigned DEF_LENGTH_WIDTH = 64;
  localparam int unsigned DEF_FIFO_DEPTH   = 2;

  localparam int unsigned BLOCK_BYTES  = 16;
  localparam int unsigned COUNT_WIDTH  = 5;
  localparam int unsigned TDATA_IN_W   = 136;
  localparam int unsigned TDATA_OUT_W  = 128;

  localparam logic [63:0] MIX_C1       = 64'h87c37b91114253d5;
  localparam logic [63:0] MIX_C2       = 64'h4cf5ad432745937f;
  localparam logic [63:0] LANE_ADD_ONE = 64'h0000000052dce729;
  localparam logic [63:0] LANE_ADD_TWO = 64'h0000000038495ab5;
  localparam logic [63:0] FIN_M1       = 64'hff51afd7ed558ccd;
  localparam logic [63:0] FIN_M2       = 64'hc4ceb9fe1a85ec53;

  typedef enum logic {
    BLK_FULL = 1'b0,
    BLK_TAIL = 1'b1
  } blk_kind_e;

  typedef struct packed {
    logic [63:0]            lo;
    logic [63:0]            hi;
    logic [COUNT_WIDTH-1:0] cnt;
    logic                   last;
    blk_kind_e              kind;
  } blk_t;

  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
  } mul_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] p;
  } mul_rsp_t;

endpackage

>>> rtl/core/mm3_mul.sv
// Shared 64x64 multiplier, low 64 bits of the product, on one 32x32 multiplier.
// Three partial products, summed one after another. Depends on mm3_pkg.
module mm3_mul (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mm3_pkg::mul_req_t req_i,
  output mm3_pkg::mul_rsp_t rsp_o
);
  import mm3_pkg::*;

  localparam logic [2:0] STEP_LAST = 3'd4;

  logic [63:0] a_q, a_d, b_q, b_d;
  logic [63:0] pp_q, pp_d, acc_q, acc_d;
  logic [2:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [31:0] x, y;
  logic        done;

  assign done = busy_q && (cnt_q == STEP_LAST);

  always_comb begin
    case (cnt_q)
      3'd0: begin
        x = a_q[31:0];
        y = b_q[31:0];
      end
      3'd1: begin
        x = a_q[31:0];
        y = b_q[63:32];
      end
      default: begin
        x = a_q[63:32];
        y = b_q[31:0];
      end
    endcase
    pp_d = {32'b0, x} * {32'b0, y};

    case (cnt_q)
      3'd1:    acc_d = pp_q;
      3'd2:    acc_d = acc_q + {pp_q[31:0], 32'b0};
      3'd3:    acc_d = acc_q + {pp_q[31:0], 32'b0};
      default: acc_d = acc_q;
    endcase

    a_d    = a_q;
    b_d    = b_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (req_i.start) begin
      a_d    = req_i.a;
      b_d    = req_i.b;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (done) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    pp_q  <= pp_d;
    acc_q <= acc_d;
  end

  assign rsp_o.done = done;
  assign rsp_o.p    = acc_q;

endmodule

>>> rtl/core/mm3_front.sv
// Front end: takes input beats, saturates the byte count, masks invalid bytes
// and tags each block as full or tail. Depends on mm3_pkg.
module mm3_front (
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [63:0] block_low, [127:64] block_high, [132:128] byte_count, [135:133] zero
  input  logic [mm3_pkg::TDATA_IN_W-1:0]     s_axis_tdata,
  input  logic                               s_axis_tlast,
  input  logic                               full_i,
  output logic                               push_o,
  output mm3_pkg::blk_t                      blk_o
);
  import mm3_pkg::*;

  localparam logic [COUNT_WIDTH-1:0] FULL_CNT = COUNT_WIDTH'(BLOCK_BYTES);

  logic [COUNT_WIDTH-1:0] cnt_raw, cnt_sat, cnt_eff;
  logic [63:0]            lo, hi, lo_m, hi_m;

  assign lo      = s_axis_tdata[63:0];
  assign hi      = s_axis_tdata[127:64];
  assign cnt_raw = s_axis_tdata[132:128];
  assign cnt_sat = (cnt_raw > FULL_CNT) ? FULL_CNT : cnt_raw;
  assign cnt_eff = s_axis_tlast ? cnt_sat : FULL_CNT;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      lo_m[8*i +: 8] = (cnt_eff > COUNT_WIDTH'(i))     ? lo[8*i +: 8] : 8'h00;
      hi_m[8*i +: 8] = (cnt_eff > COUNT_WIDTH'(i + 8)) ? hi[8*i +: 8] : 8'h00;
    end
  end

  assign blk_o.lo   = lo_m;
  assign blk_o.hi   = hi_m;
  assign blk_o.cnt  = cnt_eff;
  assign blk_o.last = s_axis_tlast;
  assign blk_o.kind = (cnt_eff == FULL_CNT) ? BLK_FULL : BLK_TAIL;

  assign s_axis_tready = !full_i;
  assign push_o        = s_axis_tvalid && !full_i;

endmodule

>>> rtl/core/mm3_fifo.sv
// Short block queue between front and back end.
// Register based, DEPTH of at least two. Depends on mm3_pkg.
module mm3_fifo #(
  parameter int unsigned DEPTH = mm3_pkg::DEF_FIFO_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  mm3_pkg::blk_t din_i,
  output logic          full_o,
  input  logic          pop_i,
  output mm3_pkg::blk_t dout_o,
  output logic          valid_o
);
  import mm3_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  blk_t             mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign dout_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= din_i;
    end
  end

endmodule

>>> rtl/core/mm3_core.sv
// Back end: lane state, seed register, sequencer over the shared multiplier,
// finalization and output register. Depends on mm3_pkg.
module mm3_core #(
  parameter int unsigned LENGTH_WIDTH = mm3_pkg::DEF_LENGTH_WIDTH
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [63:0]                     cfg_wdata_i,
  input  logic                            blk_valid_i,
  input  mm3_pkg::blk_t                   blk_i,
  output logic                            blk_pop_o,
  output mm3_pkg::mul_req_t               mul_req_o,
  input  mm3_pkg::mul_rsp_t               mul_rsp_i,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [63:0] hash_low, [127:64] hash_high
  output logic [mm3_pkg::TDATA_OUT_W-1:0] m_axis_tdata
);
  import mm3_pkg::*;

  typedef enum logic [15:0] {
    ST_IDLE = 16'h0001,
    ST_S1A  = 16'h0002,
    ST_S1B  = 16'h0004,
    ST_L1   = 16'h0008,
    ST_S2A  = 16'h0010,
    ST_S2B  = 16'h0020,
    ST_L2   = 16'h0040,
    ST_FIN  = 16'h0080,
    ST_ADD1 = 16'h0100,
    ST_ADD2 = 16'h0200,
    ST_A1A  = 16'h0400,
    ST_A1B  = 16'h0800,
    ST_A2A  = 16'h1000,
    ST_A2B  = 16'h2000,
    ST_OUT1 = 16'h4000,
    ST_OUT2 = 16'h8000
  } state_e;

  function automatic logic [63:0] fold33(input logic [63:0] v);
    fold33 = v ^ {33'b0, v[63:33]};
  endfunction

  state_e                  state_q, state_d;
  logic [63:0]             seed_q, seed_d;
  logic [63:0]             h1_q, h1_d, h2_q, h2_d;
  logic [63:0]             hi_q, hi_d;
  logic [COUNT_WIDTH-1:0]  cnt_q, cnt_d;
  logic                    last_q, last_d;
  blk_kind_e               kind_q, kind_d;
  logic [LENGTH_WIDTH-1:0] len_q, len_d, len_sum;
  logic                    in_msg_q, in_msg_d;
  logic                    out_valid_q, out_valid_d;
  logic [63:0]             out_lo_q, out_lo_d, out_hi_q, out_hi_d;
  logic [63:0]             total;
  logic [63:0]             p;

  assign p       = mul_rsp_i.p;
  assign len_sum = len_q + LENGTH_WIDTH'(cnt_q);
  assign total   = 64'(len_sum);

  always_comb begin
    state_d     = state_q;
    seed_d      = cfg_we_i ? cfg_wdata_i : seed_q;
    h1_d        = h1_q;
    h2_d        = h2_q;
    hi_d        = hi_q;
    cnt_d       = cnt_q;
    last_d      = last_q;
    kind_d      = kind_q;
    len_d       = len_q;
    in_msg_d    = in_msg_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_lo_d    = out_lo_q;
    out_hi_d    = out_hi_q;
    blk_pop_o   = 1'b0;
    mul_req_o   = '0;

    case (state_q)
      ST_IDLE: begin
        if (blk_valid_i) begin
          blk_pop_o = 1'b1;
          hi_d      = blk_i.hi;
          cnt_d     = blk_i.cnt;
          last_d    = blk_i.last;
          kind_d    = blk_i.kind;
          if (!in_msg_q) begin
            h1_d     = seed_q;
            h2_d     = seed_q;
            len_d    = '0;
            in_msg_d = 1'b1;
          end
          mul_req_o = '{start: 1'b1, a: blk_i.lo, b: MIX_C1};
          state_d   = ST_S1A;
        end
      end
      ST_S1A: begin
        if (mul_rsp_i.done) begin
          mul_req_o = '{start: 1'b1, a: {p[32:0], p[63:33]}, b: MIX_C2};
          state_d   = ST_S1B;
        end
      end
      ST_S1B: begin
        if (mul_rsp_i.done) begin
          if (kind_q == BLK_FULL) begin
            h1_d    = {h1_q[36:0] ^ p[36:0], h1_q[63:37] ^ p[63:37]} + h2_q;
            state_d = ST_L1;
          end else begin
            h1_d      = h1_q ^ p;
            mul_req_o = '{start: 1'b1, a: hi_q, b: MIX_C2};
            state_d   = ST_S2A;
          end
        end
      end
      ST_L1: begin
        h1_d      = {h1_q[61:0], 2'b00} + h1_q + LANE_ADD_ONE;
        mul_req_o = '{start: 1'b1, a: hi_q, b: MIX_C2};
        state_d   = ST_S2A;
      end
      ST_S2A: begin
        if (mul_rsp_i.done) begin
          mul_req_o = '{start: 1'b1, a: {p[30:0], p[63:31]}, b: MIX_C1};
          state_d   = ST_S2B;
        end
      end
      ST_S2B: begin
        if (mul_rsp_i.done) begin
          if (kind_q == BLK_FULL) begin
            h2_d    = {h2_q[32:0] ^ p[32:0], h2_q[63:33] ^ p[63:33]} + h1_q;
            state_d = ST_L2;
          end else begin
            h2_d    = h2_q ^ p;
            state_d = ST_FIN;
          end
        end
      end
      ST_L2: begin
        h2_d = {h2_q[61:0], 2'b00} + h2_q + LANE_ADD_TWO;
        if (last_q) begin
          state_d = ST_FIN;
        end else begin
          len_d   = len_sum;
          state_d = ST_IDLE;
        end
      end
      ST_FIN: begin
        h1_d    = h1_q ^ total;
        h2_d    = h2_q ^ total;
        state_d = ST_ADD1;
      end
      ST_ADD1: begin
        h1_d    = h1_q + h2_q;
        state_d = ST_ADD2;
      end
      ST_ADD2: begin
        h2_d      = h2_q + h1_q;
        mul_req_o = '{start: 1'b1, a: fold33(h1_q), b: FIN_M1};
        state_d   = ST_A1A;
      end
      ST_A1A: begin
        if (mul_rsp_i.done) begin
          mul_req_o = '{start: 1'b1, a: fold33(p), b: FIN_M2};
          state_d   = ST_A1B;
        end
      end
      ST_A1B: begin
        if (mul_rsp_i.done) begin
          h1_d      = fold33(p);
          mul_req_o = '{start: 1'b1, a: fold33(h2_q), b: FIN_M1};
          state_d   = ST_A2A;
        end
      end
      ST_A2A: begin
        if (mul_rsp_i.done) begin
          mul_req_o = '{start: 1'b1, a: fold33(p), b: FIN_M2};
          state_d   = ST_A2B;
        end
      end
      ST_A2B: begin
        if (mul_rsp_i.done) begin
          h2_d    = fold33(p);
          state_d = ST_OUT1;
        end
      end
      ST_OUT1: begin
        h1_d    = h1_q + h2_q;
        state_d = ST_OUT2;
      end
      ST_OUT2: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_lo_d    = h1_q;
          out_hi_d    = h2_q + h1_q;
          len_d       = '0;
          in_msg_d    = 1'b0;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      seed_q      <= '0;
      len_q       <= '0;
      in_msg_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      seed_q      <= seed_d;
      len_q       <= len_d;
      in_msg_q    <= in_msg_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    h1_q     <= h1_d;
    h2_q     <= h2_d;
    hi_q     <= hi_d;
    cnt_q    <= cnt_d;
    last_q   <= last_d;
    kind_q   <= kind_d;
    out_lo_q <= out_lo_d;
    out_hi_q <= out_hi_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_hi_q, out_lo_q};

endmodule

>>> rtl/core/murmur3_x64_128bit_hash.sv
// MurmurHash3 x64 128-bit streaming hash, top level. Depends on mm3_pkg.
// The back end takes one queued beat at a time; each 64-bit multiply runs on one
// shared 32x32 multiplier. The result is registered after the last step.
// Reset clears the sequencer, the queue, the output valid flag and the seed (to zero).
module murmur3_x64_128bit_hash #(
  parameter int unsigned LENGTH_WIDTH = mm3_pkg::DEF_LENGTH_WIDTH,
  parameter int unsigned FIFO_DEPTH   = mm3_pkg::DEF_FIFO_DEPTH
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [63:0]                     cfg_wdata_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [63:0] block_low, [127:64] block_high, [132:128] byte_count, [135:133] zero
  input  logic [mm3_pkg::TDATA_IN_W-1:0]  s_axis_tdata,
  input  logic                            s_axis_tlast,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [63:0] hash_low, [127:64] hash_high
  output logic [mm3_pkg::TDATA_OUT_W-1:0] m_axis_tdata
);
  import mm3_pkg::*;

  blk_t     blk_in, blk_out;
  logic     push, full, pop, blk_valid;
  mul_req_t mul_req;
  mul_rsp_t mul_rsp;

  mm3_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .full_i        (full),
    .push_o        (push),
    .blk_o         (blk_in)
  );

  mm3_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .din_i   (blk_in),
    .full_o  (full),
    .pop_i   (pop),
    .dout_o  (blk_out),
    .valid_o (blk_valid)
  );

  mm3_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  mm3_core #(
    .LENGTH_WIDTH (LENGTH_WIDTH)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .blk_valid_i   (blk_valid),
    .blk_i         (blk_out),
    .blk_pop_o     (pop),
    .mul_req_o     (mul_req),
    .mul_rsp_i     (mul_rsp),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule
